[src/dq_pkg.sv]
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, action and status codes, cell operations and link types.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to every cell in the same cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } t_op;

    // What one cell shows its neighbors: its word and whether it holds one.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } t_link;

endpackage

[src/dq_in_if.sv]
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel carrying one action and the word to push.
// ----------------------------------------------------------------------------
interface dq_in_if import dq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [DATA_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

[src/dq_out_if.sv]
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel carrying the popped word, status, count and both ends.
// ----------------------------------------------------------------------------
interface dq_out_if import dq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] popped_value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  item_count;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;

    modport source (output valid, output popped_value, output status,
                    output item_count, output front_value, output back_value,
                    input ready);
    modport sink   (input valid, input popped_value, input status,
                    input item_count, input front_value, input back_value,
                    output ready);
endinterface

[src/dq_cell.sv]
// ----------------------------------------------------------------------------
// Deque cell
// Holds one word of the deque and moves it toward either neighbor.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic [DATA_W-1:0] i_push_value,
    input  t_link             i_prev,
    input  t_link             i_next,
    output t_link             o_cur,
    output t_link             o_nxt
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              n_valid;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_op)
            OP_PUSH_FRONT: begin
                n_valid = i_prev.valid;
                n_data  = i_prev.data;
            end
            OP_PUSH_BACK: begin
                // The first empty cell behind a full one takes the word.
                if (!r_valid && i_prev.valid) begin
                    n_valid = 1'b1;
                    n_data  = i_push_value;
                end
            end
            OP_POP_FRONT: begin
                n_valid = i_next.valid;
                n_data  = i_next.data;
            end
            OP_POP_BACK: begin
                if (r_valid && !i_next.valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_valid = r_valid;
                n_data  = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_cur = '{valid: r_valid, data: r_data};
    assign o_nxt = '{valid: n_valid, data: n_data};

endmodule

[src/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// Double-ended queue core
// A result word is registered as its request word is taken and shows in the cycle after.
// Throughput: one request word per cycle, set by the single update of the
// cell row; a stalled result holds the input only while it is not taken.
// Reset (synchronous, active low) empties the deque and the result register;
// stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_core import dq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dq_in_if.sink  i_in,
    dq_out_if.source o_out
);

    // The deque lives in a row of DEPTH cells. Cell 0 always holds the front
    // and the occupied cells form an unbroken run from cell 0, so the back is
    // the last valid cell. A push at the front shifts the whole row one cell
    // toward the back, a pop from the front shifts it toward the front, a
    // push at the back fills the first empty cell, and a pop from the back
    // just clears the last valid cell. Every cell makes its move from its
    // own state and its two neighbors, all cells in the same cycle.

    t_link             w_cur [DEPTH];
    t_link             w_nxt [DEPTH];
    t_op               w_op;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic [DEPTH:0]    w_cur_v;
    logic [DEPTH:0]    w_nxt_v;
    logic [DATA_W-1:0] w_cur_back;
    logic [DATA_W-1:0] w_nxt_back;
    logic [DATA_W-1:0] w_popped;
    t_status           w_status;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_popped;
    logic [1:0]        r_status;
    logic [CNT_W-1:0]  r_item_count;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] r_back;

    // A new request is taken whenever the result register is free or its
    // word leaves in this same cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Decode the action; a push into a full row or a pop from an empty one
    // leaves every cell as it is.
    always_comb begin
        w_op     = OP_HOLD;
        w_status = ST_OK;
        if (w_accept) begin
            case (t_action'(i_in.action))
                ACT_PUSH_FRONT: begin
                    if (w_full) w_status = ST_FULL;
                    else        w_op     = OP_PUSH_FRONT;
                end
                ACT_PUSH_BACK: begin
                    if (w_full) w_status = ST_FULL;
                    else        w_op     = OP_PUSH_BACK;
                end
                ACT_POP_FRONT: begin
                    if (w_empty) w_status = ST_EMPTY;
                    else         w_op     = OP_POP_FRONT;
                end
                ACT_POP_BACK: begin
                    if (w_empty) w_status = ST_EMPTY;
                    else         w_op     = OP_POP_BACK;
                end
                default: begin
                    w_op     = OP_HOLD;
                    w_status = ST_OK;
                end
            endcase
        end
    end

    // The cell row. Ahead of cell 0 sits a pseudo-cell that always holds the
    // word being pushed, so a front push shifts it straight in and a back
    // push into an empty row lands in cell 0. Behind the last cell there is
    // never a word.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_link w_prev;
        t_link w_next;

        if (g == 0) begin : g_head
            assign w_prev = '{valid: 1'b1, data: i_in.push_value};
        end else begin : g_mid
            assign w_prev = w_cur[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '{valid: 1'b0, data: '0};
        end else begin : g_body
            assign w_next = w_cur[g+1];
        end

        dq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_push_value (i_in.push_value),
            .i_prev       (w_prev),
            .i_next       (w_next),
            .o_cur        (w_cur[g]),
            .o_nxt        (w_nxt[g])
        );
    end

    // The back word is the one in the last valid cell, both before the
    // update (for a pop from the back) and after it (for the result).
    always_comb begin
        w_cur_v[DEPTH] = 1'b0;
        w_nxt_v[DEPTH] = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_cur_v[i] = w_cur[i].valid;
            w_nxt_v[i] = w_nxt[i].valid;
        end
        w_cur_back = '0;
        w_nxt_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_cur_v[i] && !w_cur_v[i+1]) w_cur_back = w_cur_back | w_cur[i].data;
            if (w_nxt_v[i] && !w_nxt_v[i+1]) w_nxt_back = w_nxt_back | w_nxt[i].data;
        end
    end

    always_comb begin
        case (w_op)
            OP_POP_FRONT: w_popped = w_cur[0].data;
            OP_POP_BACK:  w_popped = w_cur_back;
            default:      w_popped = '0;
        endcase
    end

    always_comb begin
        case (w_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: n_count = r_count + CNT_W'(1);
            OP_POP_FRONT, OP_POP_BACK:   n_count = r_count - CNT_W'(1);
            default:                     n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word; both ends read zero once the deque is empty.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped     <= w_popped;
            r_status     <= w_status;
            r_item_count <= n_count;
            r_front      <= w_nxt_v[0] ? w_nxt[0].data : '0;
            r_back       <= w_nxt_back;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped;
    assign o_out.status       = r_status;
    assign o_out.item_count   = r_item_count;
    assign o_out.front_value  = r_front;
    assign o_out.back_value   = r_back;

endmodule
